FILE: src/qeas_pkg.sv
`timescale 1ns / 1ps

package qeas_pkg;

    localparam int NORMAL_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 64;
    localparam int VFRAC            = 14;
    localparam int THRESH_SHIFT     = 44;
    localparam int DIV_STEPS        = 32;
    localparam int UPC_W            = 6;
    localparam int PADDR_W          = 3;

    // register index, taken from paddr[2]
    localparam logic REG_THRESH = 1'b0;
    localparam logic [31:0] THRESH_RESET = 32'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FETCH,
        S_MLOAD,
        S_MSTEP,
        S_MSTORE,
        S_DLOAD,
        S_DSTEP,
        S_DSTORE,
        S_FIN
    } t_state;

    typedef enum logic [4:0] {
        A_S0, A_S1, A_S2, A_S3, A_S4, A_S5, A_S6, A_S7, A_S8, A_S9,
        A_C00, A_C01, A_C02, A_C11, A_C12, A_C22, A_TMP
    } t_asel;

    typedef enum logic [3:0] {
        B_S0, B_S1, B_S2, B_S3, B_S4, B_S5, B_S6, B_S7, B_S8, B_S9,
        B_X, B_Y, B_Z, B_ONE
    } t_bsel;

    typedef enum logic [1:0] {SH_0, SH_1, SH_15, SH_28} t_shsel;

    typedef enum logic [1:0] {INIT_ZERO, INIT_KEEP, INIT_E} t_init;

    typedef enum logic [3:0] {
        D_NONE, D_C00, D_C01, D_C02, D_C11, D_C12, D_C22,
        D_DET, D_NUM, D_TMP, D_E, D_X, D_Y, D_Z
    } t_dst;

    typedef enum logic [1:0] {K_MAC, K_DIV, K_END} t_kind;

    typedef struct packed {
        t_kind  kind;
        t_asel  a;
        t_bsel  b;
        logic   sub;
        t_shsel sh;
        t_init  init;
        t_dst   dst;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic mul;
        logic add;
        logic mac_load;
        logic mac_step;
        logic mac_last;
        logic mac_store;
        logic div_load;
        logic div_step;
        logic div_first;
        logic div_store;
        logic out_load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

    function automatic t_uop mk(input t_kind kind, input t_asel a, input t_bsel b,
                                input logic sub, input t_shsel sh, input t_init init,
                                input t_dst dst);
        t_uop u;
        u.kind = kind;
        u.a    = a;
        u.b    = b;
        u.sub  = sub;
        u.sh   = sh;
        u.init = init;
        u.dst  = dst;
        return u;
    endfunction

    // solve sequence: cofactors, determinant, numerators with divides, error terms
    function automatic t_uop uop_at(input logic [UPC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(K_MAC, A_S4,  B_S7,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd1:  u = mk(K_MAC, A_S5,  B_S5,  1'b1, SH_0,  INIT_KEEP, D_C00);
            6'd2:  u = mk(K_MAC, A_S2,  B_S5,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd3:  u = mk(K_MAC, A_S1,  B_S7,  1'b1, SH_0,  INIT_KEEP, D_C01);
            6'd4:  u = mk(K_MAC, A_S1,  B_S5,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd5:  u = mk(K_MAC, A_S2,  B_S4,  1'b1, SH_0,  INIT_KEEP, D_C02);
            6'd6:  u = mk(K_MAC, A_S0,  B_S7,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd7:  u = mk(K_MAC, A_S2,  B_S2,  1'b1, SH_0,  INIT_KEEP, D_C11);
            6'd8:  u = mk(K_MAC, A_S1,  B_S2,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd9:  u = mk(K_MAC, A_S0,  B_S5,  1'b1, SH_0,  INIT_KEEP, D_C12);
            6'd10: u = mk(K_MAC, A_S0,  B_S4,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd11: u = mk(K_MAC, A_S1,  B_S1,  1'b1, SH_0,  INIT_KEEP, D_C22);
            6'd12: u = mk(K_MAC, A_C00, B_S0,  1'b0, SH_0,  INIT_ZERO, D_NONE);
            6'd13: u = mk(K_MAC, A_C01, B_S1,  1'b0, SH_0,  INIT_KEEP, D_NONE);
            6'd14: u = mk(K_MAC, A_C02, B_S2,  1'b0, SH_0,  INIT_KEEP, D_DET);
            6'd15: u = mk(K_MAC, A_C00, B_S3,  1'b1, SH_0,  INIT_ZERO, D_NONE);
            6'd16: u = mk(K_MAC, A_C01, B_S6,  1'b1, SH_0,  INIT_KEEP, D_NONE);
            6'd17: u = mk(K_MAC, A_C02, B_S8,  1'b1, SH_0,  INIT_KEEP, D_NUM);
            6'd18: u = mk(K_DIV, A_TMP, B_ONE, 1'b0, SH_0,  INIT_ZERO, D_X);
            6'd19: u = mk(K_MAC, A_C01, B_S3,  1'b1, SH_0,  INIT_ZERO, D_NONE);
            6'd20: u = mk(K_MAC, A_C11, B_S6,  1'b1, SH_0,  INIT_KEEP, D_NONE);
            6'd21: u = mk(K_MAC, A_C12, B_S8,  1'b1, SH_0,  INIT_KEEP, D_NUM);
            6'd22: u = mk(K_DIV, A_TMP, B_ONE, 1'b0, SH_0,  INIT_ZERO, D_Y);
            6'd23: u = mk(K_MAC, A_C02, B_S3,  1'b1, SH_0,  INIT_ZERO, D_NONE);
            6'd24: u = mk(K_MAC, A_C12, B_S6,  1'b1, SH_0,  INIT_KEEP, D_NONE);
            6'd25: u = mk(K_MAC, A_C22, B_S8,  1'b1, SH_0,  INIT_KEEP, D_NUM);
            6'd26: u = mk(K_DIV, A_TMP, B_ONE, 1'b0, SH_0,  INIT_ZERO, D_Z);
            6'd27: u = mk(K_MAC, A_S0,  B_X,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd28: u = mk(K_MAC, A_TMP, B_X,   1'b0, SH_0,  INIT_ZERO, D_E);
            6'd29: u = mk(K_MAC, A_S4,  B_Y,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd30: u = mk(K_MAC, A_TMP, B_Y,   1'b0, SH_0,  INIT_E,    D_E);
            6'd31: u = mk(K_MAC, A_S7,  B_Z,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd32: u = mk(K_MAC, A_TMP, B_Z,   1'b0, SH_0,  INIT_E,    D_E);
            6'd33: u = mk(K_MAC, A_S1,  B_X,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd34: u = mk(K_MAC, A_TMP, B_Y,   1'b0, SH_1,  INIT_E,    D_E);
            6'd35: u = mk(K_MAC, A_S2,  B_X,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd36: u = mk(K_MAC, A_TMP, B_Z,   1'b0, SH_1,  INIT_E,    D_E);
            6'd37: u = mk(K_MAC, A_S5,  B_Y,   1'b0, SH_0,  INIT_ZERO, D_TMP);
            6'd38: u = mk(K_MAC, A_TMP, B_Z,   1'b0, SH_1,  INIT_E,    D_E);
            6'd39: u = mk(K_MAC, A_S3,  B_X,   1'b0, SH_15, INIT_E,    D_E);
            6'd40: u = mk(K_MAC, A_S6,  B_Y,   1'b0, SH_15, INIT_E,    D_E);
            6'd41: u = mk(K_MAC, A_S8,  B_Z,   1'b0, SH_15, INIT_E,    D_E);
            6'd42: u = mk(K_MAC, A_S9,  B_ONE, 1'b0, SH_28, INIT_E,    D_E);
            default: u = mk(K_END, A_TMP, B_ONE, 1'b0, SH_0, INIT_ZERO, D_NONE);
        endcase
        return u;
    endfunction

endpackage

FILE: src/qeas_ctrl.sv
`timescale 1ns / 1ps

module qeas_ctrl #(
    parameter int COEF_WIDTH = qeas_pkg::COEF_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  qeas_pkg::t_stat  i_stat,
    output qeas_pkg::t_cmd   o_cmd
);

    localparam int CNT_W = $clog2(COEF_WIDTH);
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(COEF_WIDTH - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(qeas_pkg::DIV_STEPS - 1);

    qeas_pkg::t_state r_state, n_state;
    logic [qeas_pkg::UPC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_ovalid, n_ovalid;
    qeas_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qeas_pkg::S_IDLE;
            r_pc     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        cmd      = '0;
        cmd.uop  = qeas_pkg::uop_at(r_pc);
        unique case (r_state)
            qeas_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = qeas_pkg::S_MUL;
                end
            end
            qeas_pkg::S_MUL: begin
                cmd.mul = 1'b1;
                n_state = qeas_pkg::S_ADD;
            end
            qeas_pkg::S_ADD: begin
                cmd.add = 1'b1;
                if (i_stat.last) begin
                    n_pc    = '0;
                    n_state = qeas_pkg::S_FETCH;
                end else begin
                    n_state = qeas_pkg::S_IDLE;
                end
            end
            qeas_pkg::S_FETCH: begin
                unique case (cmd.uop.kind)
                    qeas_pkg::K_MAC: n_state = qeas_pkg::S_MLOAD;
                    qeas_pkg::K_DIV: n_state = qeas_pkg::S_DLOAD;
                    default:         n_state = qeas_pkg::S_FIN;
                endcase
            end
            qeas_pkg::S_MLOAD: begin
                cmd.mac_load = 1'b1;
                n_cnt        = '0;
                n_state      = qeas_pkg::S_MSTEP;
            end
            qeas_pkg::S_MSTEP: begin
                cmd.mac_step = 1'b1;
                cmd.mac_last = (r_cnt == MAC_LAST);
                if (r_cnt == MAC_LAST) begin
                    n_state = qeas_pkg::S_MSTORE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            qeas_pkg::S_MSTORE: begin
                cmd.mac_store = 1'b1;
                n_pc          = r_pc + 1'b1;
                n_state       = qeas_pkg::S_FETCH;
            end
            qeas_pkg::S_DLOAD: begin
                cmd.div_load = 1'b1;
                n_cnt        = '0;
                n_state      = qeas_pkg::S_DSTEP;
            end
            qeas_pkg::S_DSTEP: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (r_cnt == '0);
                if (r_cnt == DIV_LAST) begin
                    n_state = qeas_pkg::S_DSTORE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            qeas_pkg::S_DSTORE: begin
                cmd.div_store = 1'b1;
                n_pc          = r_pc + 1'b1;
                n_state       = qeas_pkg::S_FETCH;
            end
            qeas_pkg::S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = qeas_pkg::S_IDLE;
                end
            end
            default: n_state = qeas_pkg::S_IDLE;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != qeas_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;

    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == qeas_pkg::S_MUL))
        else $error("accepted plane did not move to multiply");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_ovalid || !i_out_stall))
        else $error("result overwritten before taken");

    a_mac_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qeas_pkg::S_MSTEP) |-> (r_cnt <= MAC_LAST))
        else $error("multiply counter out of range");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qeas_pkg::S_DSTEP) |-> (r_cnt <= DIV_LAST))
        else $error("divide counter out of range");

endmodule

FILE: src/qeas_dpath.sv
`timescale 1ns / 1ps

module qeas_dpath #(
    parameter int NORMAL_WIDTH = qeas_pkg::NORMAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = qeas_pkg::COEF_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  qeas_pkg::t_cmd                 i_cmd,
    output qeas_pkg::t_stat                o_stat,
    input  logic [31:0]                    i_thresh,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_x,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_y,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_z,
    input  logic signed [31:0]             i_plane_offset,
    input  logic [31:0]                    i_face_area,
    input  logic                           i_first_plane,
    input  logic                           i_last_plane,
    output logic signed [31:0]             o_opt_x,
    output logic signed [31:0]             o_opt_y,
    output logic signed [31:0]             o_opt_z,
    output logic signed [63:0]             o_vertex_error,
    output logic                           o_solved,
    output logic [31:0]                    o_total_area,
    output logic                           o_saturated
);

    localparam int WIDE_W = 4 * COEF_WIDTH + 32;
    localparam int NW     = NORMAL_WIDTH;
    localparam logic signed [65:0] SUM_HI = (66'sd1 <<< (COEF_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] SUM_LO = -(66'sd1 <<< (COEF_WIDTH - 1));

    // input item
    logic signed [NW-1:0] r_nx, r_ny, r_nz;
    logic signed [31:0]   r_d;
    logic [31:0]          r_area_in;
    logic                 r_first, r_last;

    // plane products and running sums
    logic signed [63:0]           r_p [10];
    logic signed [COEF_WIDTH-1:0] r_s [10];
    logic [31:0]                  r_area_sum;
    logic                         r_ovf;

    logic signed [2*NW-1:0] p_aa, p_ab, p_ac, p_bb, p_bc, p_cc;
    logic signed [NW+31:0]  p_ad, p_bd, p_cd;
    logic signed [63:0]     p_dd;

    logic signed [65:0]           sum [10];
    logic signed [COEF_WIDTH-1:0] n_s [10];
    logic [9:0]                   clamp;
    logic [32:0]                  asum;
    logic [31:0]                  n_area;
    logic                         n_ovf;

    // solve registers
    logic signed [WIDE_W-1:0] r_c00, r_c01, r_c02, r_c11, r_c12, r_c22;
    logic signed [WIDE_W-1:0] r_det, r_num, r_tmp, r_e;
    logic signed [WIDE_W-1:0] r_acc, r_a;
    logic [COEF_WIDTH-1:0]    r_b;
    logic signed [31:0]       r_x, r_y, r_z;

    logic [WIDE_W-1:0] r_rem, r_dsh;
    logic [31:0]       r_q;
    logic              r_qneg, r_dstop;

    logic signed [WIDE_W-1:0] a_src, a_sh, a_load;
    logic [COEF_WIDTH-1:0]    b_src;
    logic [WIDE_W-1:0]        det_abs, num_abs, lim;
    logic                     ok;
    logic                     take;
    logic [31:0]              q_val, coord;

    logic [WIDE_W-1:0] e_abs, e_shr;
    logic              e_big;
    logic [63:0]       e_mag, e_out;

    assign p_aa = r_nx * r_nx;
    assign p_ab = r_nx * r_ny;
    assign p_ac = r_nx * r_nz;
    assign p_bb = r_ny * r_ny;
    assign p_bc = r_ny * r_nz;
    assign p_cc = r_nz * r_nz;
    assign p_ad = r_nx * r_d;
    assign p_bd = r_ny * r_d;
    assign p_cd = r_nz * r_d;
    assign p_dd = r_d * r_d;

    // saturating accumulate, first plane starts from zero
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            sum[i]   = (r_first ? 66'sd0 : 66'(r_s[i])) + 66'(r_p[i]);
            clamp[i] = (sum[i] > SUM_HI) || (sum[i] < SUM_LO);
            if (sum[i] > SUM_HI) begin
                n_s[i] = COEF_WIDTH'(SUM_HI);
            end else if (sum[i] < SUM_LO) begin
                n_s[i] = COEF_WIDTH'(SUM_LO);
            end else begin
                n_s[i] = COEF_WIDTH'(sum[i]);
            end
        end
        asum   = (r_first ? 33'd0 : {1'b0, r_area_sum}) + {1'b0, r_area_in};
        n_area = asum[32] ? 32'hFFFF_FFFF : asum[31:0];
        n_ovf  = (!r_first && r_ovf) || (|clamp) || asum[32];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_nx      <= i_normal_x;
            r_ny      <= i_normal_y;
            r_nz      <= i_normal_z;
            r_d       <= i_plane_offset;
            r_area_in <= i_face_area;
            r_first   <= i_first_plane;
            r_last    <= i_last_plane;
        end
        if (i_cmd.mul) begin
            r_p[0] <= 64'(p_aa);
            r_p[1] <= 64'(p_ab);
            r_p[2] <= 64'(p_ac);
            r_p[3] <= 64'(p_ad);
            r_p[4] <= 64'(p_bb);
            r_p[5] <= 64'(p_bc);
            r_p[6] <= 64'(p_bd);
            r_p[7] <= 64'(p_cc);
            r_p[8] <= 64'(p_cd);
            r_p[9] <= p_dd;
        end
    end

    // sums start from zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 10; i++) begin
                r_s[i] <= '0;
            end
            r_area_sum <= '0;
            r_ovf      <= 1'b0;
        end else if (i_cmd.add) begin
            for (int i = 0; i < 10; i++) begin
                r_s[i] <= n_s[i];
            end
            r_area_sum <= n_area;
            r_ovf      <= n_ovf;
        end
    end

    assign o_stat.last = r_last;

    // operand select for the serial multiplier
    always_comb begin
        unique case (i_cmd.uop.a)
            qeas_pkg::A_S0:  a_src = WIDE_W'(r_s[0]);
            qeas_pkg::A_S1:  a_src = WIDE_W'(r_s[1]);
            qeas_pkg::A_S2:  a_src = WIDE_W'(r_s[2]);
            qeas_pkg::A_S3:  a_src = WIDE_W'(r_s[3]);
            qeas_pkg::A_S4:  a_src = WIDE_W'(r_s[4]);
            qeas_pkg::A_S5:  a_src = WIDE_W'(r_s[5]);
            qeas_pkg::A_S6:  a_src = WIDE_W'(r_s[6]);
            qeas_pkg::A_S7:  a_src = WIDE_W'(r_s[7]);
            qeas_pkg::A_S8:  a_src = WIDE_W'(r_s[8]);
            qeas_pkg::A_S9:  a_src = WIDE_W'(r_s[9]);
            qeas_pkg::A_C00: a_src = r_c00;
            qeas_pkg::A_C01: a_src = r_c01;
            qeas_pkg::A_C02: a_src = r_c02;
            qeas_pkg::A_C11: a_src = r_c11;
            qeas_pkg::A_C12: a_src = r_c12;
            qeas_pkg::A_C22: a_src = r_c22;
            default:         a_src = r_tmp;
        endcase
        unique case (i_cmd.uop.b)
            qeas_pkg::B_S0: b_src = r_s[0];
            qeas_pkg::B_S1: b_src = r_s[1];
            qeas_pkg::B_S2: b_src = r_s[2];
            qeas_pkg::B_S3: b_src = r_s[3];
            qeas_pkg::B_S4: b_src = r_s[4];
            qeas_pkg::B_S5: b_src = r_s[5];
            qeas_pkg::B_S6: b_src = r_s[6];
            qeas_pkg::B_S7: b_src = r_s[7];
            qeas_pkg::B_S8: b_src = r_s[8];
            qeas_pkg::B_S9: b_src = r_s[9];
            qeas_pkg::B_X:  b_src = COEF_WIDTH'(r_x);
            qeas_pkg::B_Y:  b_src = COEF_WIDTH'(r_y);
            qeas_pkg::B_Z:  b_src = COEF_WIDTH'(r_z);
            default:        b_src = {{(COEF_WIDTH-1){1'b0}}, 1'b1};
        endcase
        unique case (i_cmd.uop.sh)
            qeas_pkg::SH_1:  a_sh = a_src <<< 1;
            qeas_pkg::SH_15: a_sh = a_src <<< (qeas_pkg::VFRAC + 1);
            qeas_pkg::SH_28: a_sh = a_src <<< (2 * qeas_pkg::VFRAC);
            default:         a_sh = a_src;
        endcase
        a_load = i_cmd.uop.sub ? -a_sh : a_sh;
    end

    // shift-add multiply, top bit of b carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_load) begin
            r_a <= a_load;
            r_b <= b_src;
            case (i_cmd.uop.init)
                qeas_pkg::INIT_KEEP: r_acc <= r_acc;
                qeas_pkg::INIT_E:    r_acc <= r_e;
                default:             r_acc <= '0;
            endcase
        end
        if (i_cmd.mac_step) begin
            if (r_b[0]) begin
                r_acc <= i_cmd.mac_last ? (r_acc - r_a) : (r_acc + r_a);
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
        if (i_cmd.mac_store) begin
            case (i_cmd.uop.dst)
                qeas_pkg::D_C00: r_c00 <= r_acc;
                qeas_pkg::D_C01: r_c01 <= r_acc;
                qeas_pkg::D_C02: r_c02 <= r_acc;
                qeas_pkg::D_C11: r_c11 <= r_acc;
                qeas_pkg::D_C12: r_c12 <= r_acc;
                qeas_pkg::D_C22: r_c22 <= r_acc;
                qeas_pkg::D_DET: r_det <= r_acc;
                qeas_pkg::D_NUM: r_num <= r_acc;
                qeas_pkg::D_TMP: r_tmp <= r_acc;
                qeas_pkg::D_E:   r_e   <= r_acc;
                default: ;
            endcase
        end
    end

    assign det_abs = r_det[WIDE_W-1] ? WIDE_W'(-r_det) : WIDE_W'(r_det);
    assign num_abs = r_num[WIDE_W-1] ? WIDE_W'(-r_num) : WIDE_W'(r_num);
    assign lim     = WIDE_W'(i_thresh) << qeas_pkg::THRESH_SHIFT;
    assign ok      = det_abs > lim;

    // restoring divide; a hit on the first step clamps the quotient to 2^31-1, or -2^31 if negative
    assign take  = (r_rem >= r_dsh) && !r_dstop;
    assign q_val = r_qneg ? (32'd0 - r_q) : (r_q[31] ? 32'h7FFF_FFFF : r_q);
    assign coord = ok ? q_val : 32'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem   <= num_abs << qeas_pkg::VFRAC;
            r_dsh   <= det_abs << (qeas_pkg::DIV_STEPS - 1);
            r_q     <= '0;
            r_qneg  <= r_num[WIDE_W-1] ^ r_det[WIDE_W-1];
            r_dstop <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_q <= {r_q[30:0], take};
            if (take && !i_cmd.div_first) begin
                r_rem <= r_rem - r_dsh;
            end
            if (i_cmd.div_first) begin
                r_dstop <= take;
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.uop.dst)
                qeas_pkg::D_X: r_x <= coord;
                qeas_pkg::D_Y: r_y <= coord;
                default:       r_z <= coord;
            endcase
        end
    end

    // error back to 28 fraction bits, toward zero, saturated
    assign e_abs = r_e[WIDE_W-1] ? WIDE_W'(-r_e) : WIDE_W'(r_e);
    assign e_shr = e_abs >> (2 * qeas_pkg::VFRAC);
    assign e_big = |e_shr[WIDE_W-1:63];
    assign e_mag = e_shr[63:0];

    always_comb begin
        if (r_e[WIDE_W-1]) begin
            e_out = e_big ? 64'h8000_0000_0000_0000 : (64'd0 - e_mag);
        end else begin
            e_out = e_big ? 64'h7FFF_FFFF_FFFF_FFFF : e_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_opt_x        <= r_x;
            o_opt_y        <= r_y;
            o_opt_z        <= r_z;
            o_vertex_error <= e_out;
            o_solved       <= ok;
            o_total_area   <= r_area_sum;
            o_saturated    <= r_ovf;
        end
    end

endmodule

FILE: src/quadric_error_accumulate_solve.sv
`timescale 1ns / 1ps

// Quadric error accumulator and vertex solver. Each plane transaction (normal in
// Q1.14, offset in Q17.14, area weight) is turned into the ten products of its
// 4x4 quadric and added into saturating sums; first_plane restarts the sums.
// A plane is registered, multiplied and accumulated in turn. On last_plane the block
// solves A v = -b through the 3x3 adjugate and determinant, using one shift-add
// multiplier for all 40 products and one restoring divider for the three
// coordinates; inputs are stalled during the solve. The result transaction sits
// in an output register, so the next run starts while it waits. Singular systems
// (|det| at or below singular_threshold * 2^-40) give a zero vertex and solved
// low. The one register, singular_threshold (reset 1), sits at byte address 0 of
// the APB port.

module quadric_error_accumulate_solve #(
    parameter int NORMAL_WIDTH = qeas_pkg::NORMAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = qeas_pkg::COEF_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // plane channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [NORMAL_WIDTH-1:0]  i_normal_x,
    input  logic signed [NORMAL_WIDTH-1:0]  i_normal_y,
    input  logic signed [NORMAL_WIDTH-1:0]  i_normal_z,
    input  logic signed [31:0]              i_plane_offset,
    input  logic [31:0]                     i_face_area,
    input  logic                            i_first_plane,
    input  logic                            i_last_plane,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_opt_x,
    output logic signed [31:0]              o_opt_y,
    output logic signed [31:0]              o_opt_z,
    output logic signed [63:0]              o_vertex_error,
    output logic                            o_solved,
    output logic [31:0]                     o_total_area,
    output logic                            o_saturated,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qeas_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    qeas_pkg::t_cmd  cmd;
    qeas_pkg::t_stat stat;
    logic [31:0]     r_thresh;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= qeas_pkg::THRESH_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == qeas_pkg::REG_THRESH)) begin
            r_thresh <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == qeas_pkg::REG_THRESH) ? r_thresh : 32'd0;

    // sequencer: plane handshake, solve program, output register
    qeas_ctrl #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // sums, multiplier, divider and result formatting
    qeas_dpath #(
        .NORMAL_WIDTH (NORMAL_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_thresh       (r_thresh),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_plane_offset (i_plane_offset),
        .i_face_area    (i_face_area),
        .i_first_plane  (i_first_plane),
        .i_last_plane   (i_last_plane),
        .o_opt_x        (o_opt_x),
        .o_opt_y        (o_opt_y),
        .o_opt_z        (o_opt_z),
        .o_vertex_error (o_vertex_error),
        .o_solved       (o_solved),
        .o_total_area   (o_total_area),
        .o_saturated    (o_saturated)
    );

endmodule
